[sv/fhl_pkg.sv]
`default_nettype none
package fhl_pkg;

  localparam int SLOT_W  = 6;
  localparam int ID_W    = 16;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 7;
  localparam int KIND_W  = 3;

  localparam logic [KIND_W-1:0] KIND_RAISE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ACK     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ONGOING = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NEXT    = 3'd4;
  localparam logic [KIND_W-1:0] KIND_TICK    = 3'd5;

  localparam logic [0:0] REG_BASE_TIME  = 1'd0;
  localparam logic [0:0] REG_SCAN_START = 1'd1;

  localparam logic [ID_W-1:0] FILLER_ID = 16'hFFFF;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 88;

  // One log entry as stored in the entry memory.
  typedef struct packed {
    logic [ID_W-1:0]   device;
    logic [ID_W-1:0]   code;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Outcome of the unacknowledged-entry search.
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
  } scan_res_t;

endpackage
`default_nettype wire

[sv/fhl_ram.sv]
`default_nettype none
module fhl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[sv/fhl_scan.sv]
`default_nettype none
module fhl_scan #(
  parameter int DEPTH = 32
) (
  input  wire logic [DEPTH-1:0]         pending,
  input  wire logic [$clog2(DEPTH)-1:0] start,
  output fhl_pkg::scan_res_t            res
);

  localparam int AW = $clog2(DEPTH);

  logic [2*DEPTH-1:0] doubled;
  logic [DEPTH-1:0]   rotated;
  logic [AW-1:0]      pos;
  logic               hit;
  logic [AW:0]        sum;
  logic [AW:0]        wrapped;

  // Rotate so that the start slot sits at bit 0, then take the lowest set bit.
  always_comb begin
    doubled = {pending, pending};
    rotated = DEPTH'(doubled >> start);
    pos     = '0;
    hit     = 1'b0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (rotated[i]) begin
        pos = AW'(i);
        hit = 1'b1;
      end
    end
    sum     = (AW + 1)'(start) + (AW + 1)'(pos);
    wrapped = (sum >= (AW + 1)'(DEPTH)) ? sum - (AW + 1)'(DEPTH) : sum;
    res.found = hit;
    res.slot  = fhl_pkg::SLOT_W'(wrapped[AW-1:0]);
  end

endmodule
`default_nettype wire

[sv/fault_history_log_core.sv]
// Fault history log: a ring of LOG_DEPTH fault entries with acknowledge and
// ongoing marks.
// Input channel (in_*): one word per command. in_tuser carries the command
// kind (raise, acknowledge, set ongoing, read, next unacknowledged, tick),
// in_tdata the device, fault code, slot index and ongoing flag.
// Result channel (out_*): exactly one word per command, in command order,
// with the returned entry, the count of unacknowledged entries and the
// slot the next new fault will occupy.
// Configuration channel (cfg_*): base_time (index 0) and scan_start
// (index 1); write only while no command is in flight.
// Each command goes from the accept cycle to the result state: the accept
// cycle updates the flag vectors and issues the entry memory access, and the
// result state forms the result from the registered memory read data. A new
// command is taken only once the last one has left its result state; a result
// waits in the output register while the next command is accepted, and a
// stalled receiver holds the block in its result state until the output register frees up.
// Reset clears the ring to its filler state (device and code all ones,
// time zero, acknowledged, not ongoing) at once through per-entry valid
// bits; there is no clearing pass.
`default_nettype none
module fault_history_log_core #(
  parameter int LOG_DEPTH = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // in_tdata, lowest bit up: device_id[15:0], fault_code[15:0],
  // slot_index[5:0], ongoing_flag, one pad bit.
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [fhl_pkg::IN_TDATA_W-1:0]       in_tdata,
  // in_tuser: kind[2:0].
  input  wire logic [fhl_pkg::KIND_W-1:0]           in_tuser,
  // out_tdata, lowest bit up: found, entry_slot[5:0], entry_device[15:0],
  // entry_code[15:0], entry_time[31:0], entry_acked, entry_ongoing,
  // unacked_count[6:0], write_slot[5:0], two pad bits.
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [fhl_pkg::OUT_TDATA_W-1:0]           out_tdata,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [0:0]                           cfg_index,
  input  wire logic [31:0]                          cfg_data
);

  localparam int AW = $clog2(LOG_DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RESP = 1'b1;

  typedef logic [AW-1:0] start_tbl_t [64];

  // scan_start modulo the depth, worked out at elaboration for every code.
  function automatic start_tbl_t build_start_tbl();
    start_tbl_t tbl;
    for (int i = 0; i < 64; i++) begin
      tbl[i] = AW'(i % LOG_DEPTH);
    end
    return tbl;
  endfunction

  localparam start_tbl_t START_TBL = build_start_tbl();

  // Input word fields.
  logic [fhl_pkg::ID_W-1:0]   in_dev;
  logic [fhl_pkg::ID_W-1:0]   in_code;
  logic [fhl_pkg::SLOT_W-1:0] in_slot;
  logic                       in_flag;
  logic                       in_take;
  logic                       idx_ok;

  assign in_dev  = in_tdata[15:0];
  assign in_code = in_tdata[31:16];
  assign in_slot = in_tdata[37:32];
  assign in_flag = in_tdata[38];

  // Architectural state.
  logic                        state_r, state_nxt;
  logic [LOG_DEPTH-1:0]        ack_r, ack_nxt;
  logic [LOG_DEPTH-1:0]        ongoing_r, ongoing_nxt;
  logic [LOG_DEPTH-1:0]        valid_r, valid_nxt;
  logic [AW-1:0]               wslot_r, wslot_nxt;
  logic [fhl_pkg::TIME_W-1:0]  tick_r, tick_nxt;
  logic [fhl_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [fhl_pkg::ID_W-1:0]    last_dev_r, last_dev_nxt;
  logic [fhl_pkg::ID_W-1:0]    last_code_r, last_code_nxt;
  logic [fhl_pkg::TIME_W-1:0]  base_time_r;
  logic [AW-1:0]               scan_start_r;

  // Command in flight between the accept and result cycles.
  logic                        pend_found_r, pend_found_nxt;
  logic                        pend_raise_r, pend_raise_nxt;
  logic [AW-1:0]               pend_slot_r, pend_slot_nxt;
  fhl_pkg::entry_t             pend_entry_r, pend_entry_nxt;

  // Output register.
  logic                           out_valid_r, out_valid_nxt;
  logic [fhl_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // Entry memory port.
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  fhl_pkg::entry_t       ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [fhl_pkg::ENTRY_W-1:0] ram_rdata;

  fhl_pkg::scan_res_t    scan_res;
  logic [fhl_pkg::TIME_W-1:0] now;
  logic [AW-1:0]         prev_slot;
  logic                  raise_match;
  fhl_pkg::entry_t       res_entry;

  fhl_ram #(
    .WIDTH (fhl_pkg::ENTRY_W),
    .DEPTH (LOG_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The search looks for entries whose acknowledge mark is clear.
  fhl_scan #(
    .DEPTH (LOG_DEPTH)
  ) u_scan (
    .pending (~ack_r),
    .start   (scan_start_r),
    .res     (scan_res)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_take    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign now       = base_time_r + tick_r;
  assign prev_slot = (wslot_r == '0) ? AW'(LOG_DEPTH - 1) : wslot_r - AW'(1);
  // The newest entry's device and code are mirrored in registers, so a raise
  // decides between refresh and new entry without a memory read.
  assign raise_match = (in_dev == last_dev_r) && (in_code == last_code_r);
  assign idx_ok      = (7'(in_slot) < 7'(LOG_DEPTH));

  // Accept cycle: update the flag vectors and counters, issue the memory
  // write of a raise or the read of any command that returns an entry.
  // Outside the accept cycle the read address stays on the pending slot, so
  // the read data holds while the result waits for the output register.
  always_comb begin
    state_nxt      = state_r;
    ack_nxt        = ack_r;
    ongoing_nxt    = ongoing_r;
    valid_nxt      = valid_r;
    wslot_nxt      = wslot_r;
    tick_nxt       = tick_r;
    count_nxt      = count_r;
    last_dev_nxt   = last_dev_r;
    last_code_nxt  = last_code_r;
    pend_found_nxt = pend_found_r;
    pend_raise_nxt = pend_raise_r;
    pend_slot_nxt  = pend_slot_r;
    pend_entry_nxt = pend_entry_r;
    ram_we         = 1'b0;
    ram_waddr      = wslot_r;
    ram_wdata      = '{device: in_dev, code: in_code, stamp: now};
    ram_raddr      = pend_slot_r;

    if (in_take) begin
      state_nxt      = S_RESP;
      pend_found_nxt = 1'b0;
      pend_raise_nxt = 1'b0;
      pend_slot_nxt  = in_slot[AW-1:0];
      ram_raddr      = in_slot[AW-1:0];
      unique case (in_tuser)
        fhl_pkg::KIND_RAISE: begin
          pend_found_nxt = 1'b1;
          pend_raise_nxt = 1'b1;
          ram_we         = 1'b1;
          if (raise_match) begin
            // Refresh the newest entry's timestamp only.
            ram_waddr      = prev_slot;
            valid_nxt[prev_slot] = 1'b1;
            pend_slot_nxt  = prev_slot;
          end else begin
            ram_waddr            = wslot_r;
            valid_nxt[wslot_r]   = 1'b1;
            ack_nxt[wslot_r]     = 1'b0;
            ongoing_nxt[wslot_r] = 1'b0;
            if (ack_r[wslot_r]) begin
              count_nxt = count_r + 7'd1;
            end
            last_dev_nxt  = in_dev;
            last_code_nxt = in_code;
            pend_slot_nxt = wslot_r;
            wslot_nxt     = (wslot_r == AW'(LOG_DEPTH - 1)) ? '0 : wslot_r + AW'(1);
          end
          pend_entry_nxt = ram_wdata;
          pend_entry_nxt.device = raise_match ? last_dev_r : in_dev;
          pend_entry_nxt.code   = raise_match ? last_code_r : in_code;
          ram_wdata = pend_entry_nxt;
        end
        fhl_pkg::KIND_ACK: begin
          if (idx_ok) begin
            pend_found_nxt = 1'b1;
            if (!ack_r[in_slot[AW-1:0]]) begin
              count_nxt = count_r - 7'd1;
            end
            ack_nxt[in_slot[AW-1:0]] = 1'b1;
          end
        end
        fhl_pkg::KIND_ONGOING: begin
          if (idx_ok) begin
            pend_found_nxt = 1'b1;
            ongoing_nxt[in_slot[AW-1:0]] = in_flag;
          end
        end
        fhl_pkg::KIND_READ: begin
          pend_found_nxt = idx_ok;
        end
        fhl_pkg::KIND_NEXT: begin
          pend_found_nxt = scan_res.found;
          pend_slot_nxt  = scan_res.slot[AW-1:0];
          ram_raddr      = scan_res.slot[AW-1:0];
        end
        fhl_pkg::KIND_TICK: begin
          tick_nxt = tick_r + 32'd1;
        end
        default: begin
        end
      endcase
    end else if (state_r == S_RESP && (!out_valid_r || out_tready)) begin
      state_nxt = S_IDLE;
    end
  end

  // Result cycle: a raise returns what it wrote, every other command the
  // memory word, with never-written slots reading as filler.
  always_comb begin
    if (pend_raise_r) begin
      res_entry = pend_entry_r;
    end else if (valid_r[pend_slot_r]) begin
      res_entry = fhl_pkg::entry_t'(ram_rdata);
    end else begin
      res_entry = '{device: fhl_pkg::FILLER_ID, code: fhl_pkg::FILLER_ID, stamp: '0};
    end

    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (state_r == S_RESP && (!out_valid_r || out_tready)) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      if (pend_found_r) begin
        out_data_nxt[0]     = 1'b1;
        out_data_nxt[6:1]   = fhl_pkg::SLOT_W'(pend_slot_r);
        out_data_nxt[22:7]  = res_entry.device;
        out_data_nxt[38:23] = res_entry.code;
        out_data_nxt[70:39] = res_entry.stamp;
        out_data_nxt[71]    = ack_r[pend_slot_r];
        out_data_nxt[72]    = ongoing_r[pend_slot_r];
      end
      out_data_nxt[79:73] = count_r;
      out_data_nxt[85:80] = fhl_pkg::SLOT_W'(wslot_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ack_r        <= '1;
      ongoing_r    <= '0;
      valid_r      <= '0;
      wslot_r      <= '0;
      tick_r       <= '0;
      count_r      <= '0;
      last_dev_r   <= fhl_pkg::FILLER_ID;
      last_code_r  <= fhl_pkg::FILLER_ID;
      base_time_r  <= '0;
      scan_start_r <= '0;
      out_valid_r  <= 1'b0;
      pend_found_r <= 1'b0;
      pend_raise_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ack_r        <= ack_nxt;
      ongoing_r    <= ongoing_nxt;
      valid_r      <= valid_nxt;
      wslot_r      <= wslot_nxt;
      tick_r       <= tick_nxt;
      count_r      <= count_nxt;
      last_dev_r   <= last_dev_nxt;
      last_code_r  <= last_code_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_found_r <= pend_found_nxt;
      pend_raise_r <= pend_raise_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          fhl_pkg::REG_BASE_TIME:  base_time_r  <= cfg_data;
          fhl_pkg::REG_SCAN_START: scan_start_r <= START_TBL[cfg_data[5:0]];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_slot_r  <= pend_slot_nxt;
    pend_entry_r <= pend_entry_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
`default_nettype none
module tb_top;

  localparam int LOG_DEPTH = 32;
  // Kinds 6 and 7 are not defined by the block; they must leave the log alone.
  localparam logic [fhl_pkg::KIND_W-1:0] KIND_SPARE_A = 3'd6;
  localparam logic [fhl_pkg::KIND_W-1:0] KIND_SPARE_B = 3'd7;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES        = 6;
  localparam int PHASE_WORDS   = 250;
  localparam int N_DIRECTED    = 24;
  localparam int PRINT_CAP     = 40;

  // One command word as it travels on the input channel.
  typedef struct packed {
    logic [fhl_pkg::KIND_W-1:0]  kind;
    logic [fhl_pkg::ID_W-1:0]    device;
    logic [fhl_pkg::ID_W-1:0]    code;
    logic [fhl_pkg::SLOT_W-1:0]  slot;
    logic                        flag;
  } command_t;

  // One result word, unpacked from out_tdata.
  typedef struct packed {
    logic                         found;
    logic [fhl_pkg::SLOT_W-1:0]   slot;
    logic [fhl_pkg::ID_W-1:0]     device;
    logic [fhl_pkg::ID_W-1:0]     code;
    logic [fhl_pkg::TIME_W-1:0]   stamp;
    logic                         acked;
    logic                         ongoing;
    logic [fhl_pkg::COUNT_W-1:0]  unacked;
    logic [fhl_pkg::SLOT_W-1:0]   wslot;
  } log_word_t;

  // A directed row carries its own expected word only when "typed" is set.
  typedef struct packed {
    command_t  cmd;
    logic      typed;
    log_word_t want;
  } directed_row_t;

  localparam log_word_t NO_ENTRY = '0;
  localparam log_word_t FILLER_SLOT0 =
    '{1'b1, 6'd0, 16'hFFFF, 16'hFFFF, 32'd0, 1'b1, 1'b0, 7'd0, 6'd0};
  localparam log_word_t FILLER_REFRESHED =
    '{1'b1, 6'd31, 16'hFFFF, 16'hFFFF, 32'd1, 1'b1, 1'b0, 7'd0, 6'd0};
  localparam log_word_t FIRST_FAULT =
    '{1'b1, 6'd0, 16'h0000, 16'h0000, 32'd1, 1'b0, 1'b0, 7'd1, 6'd1};

  // The directed part starts from reset with base_time and scan_start at zero.
  // The first rows walk the filler state, where the answer is obvious; the
  // rest go through the predictor.
  localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{'{fhl_pkg::KIND_READ,    16'h0000, 16'h0000, 6'd0,  1'b0}, 1'b1, FILLER_SLOT0},
    '{'{fhl_pkg::KIND_READ,    16'h0000, 16'h0000, 6'd63, 1'b0}, 1'b1, NO_ENTRY},
    '{'{fhl_pkg::KIND_NEXT,    16'h0000, 16'h0000, 6'd0,  1'b0}, 1'b1, NO_ENTRY},
    '{'{fhl_pkg::KIND_TICK,    16'h0000, 16'h0000, 6'd0,  1'b0}, 1'b1, NO_ENTRY},
    '{'{fhl_pkg::KIND_RAISE,   16'hFFFF, 16'hFFFF, 6'd0,  1'b0}, 1'b1, FILLER_REFRESHED},
    '{'{fhl_pkg::KIND_RAISE,   16'h0000, 16'h0000, 6'd0,  1'b0}, 1'b1, FIRST_FAULT},
    '{'{fhl_pkg::KIND_RAISE,   16'h0000, 16'h0000, 6'd0,  1'b0}, 1'b1, FIRST_FAULT},
    '{'{fhl_pkg::KIND_RAISE,   16'hFFFF, 16'h0000, 6'd0,  1'b0}, 1'b0, NO_ENTRY},
    '{'{fhl_pkg::KIND_RAISE,   16'h0000, 16'hFFFF, 6'd0,  1'b0}, 1'b0, NO_ENTRY},
    '{'{fhl_pkg::KIND_RAISE,   16'hA5A5, 16'h5A5A, 6'd0,  1'b0}, 1'b0, NO_ENTRY},
    '{'{fhl_pkg::KIND_ONGOING, 16'h0000, 16'h0000, 6'd2,  1'b1}, 1'b0, NO_ENTRY},
    '{'{fhl_pkg::KIND_ONGOING, 16'h0000, 16'h0000, 6'd2,  1'b0}, 1'b0, NO_ENTRY},
    '{'{fhl_pkg::KIND_ONGOING, 16'h0000, 16'h0000, 6'd31, 1'b1}, 1'b0, NO_ENTRY},
    '{'{fhl_pkg::KIND_ONGOING, 16'h0000, 16'h0000, 6'd40, 1'b1}, 1'b0, NO_ENTRY},
    '{'{fhl_pkg::KIND_ACK,     16'h0000, 16'h0000, 6'd0,  1'b0}, 1'b0, NO_ENTRY},
    '{'{fhl_pkg::KIND_ACK,     16'h0000, 16'h0000, 6'd63, 1'b0}, 1'b0, NO_ENTRY},
    '{'{fhl_pkg::KIND_ACK,     16'h0000, 16'h0000, 6'd31, 1'b0}, 1'b0, NO_ENTRY},
    '{'{fhl_pkg::KIND_NEXT,    16'h0000, 16'h0000, 6'd0,  1'b0}, 1'b0, NO_ENTRY},
    '{'{fhl_pkg::KIND_READ,    16'h0000, 16'h0000, 6'd32, 1'b0}, 1'b0, NO_ENTRY},
    '{'{fhl_pkg::KIND_READ,    16'h0000, 16'h0000, 6'd31, 1'b0}, 1'b0, NO_ENTRY},
    '{'{KIND_SPARE_A,          16'hFFFF, 16'hFFFF, 6'd63, 1'b1}, 1'b0, NO_ENTRY},
    '{'{KIND_SPARE_B,          16'h0000, 16'h0000, 6'd0,  1'b0}, 1'b0, NO_ENTRY},
    '{'{fhl_pkg::KIND_TICK,    16'h0000, 16'h0000, 6'd0,  1'b0}, 1'b0, NO_ENTRY},
    '{'{fhl_pkg::KIND_RAISE,   16'h5A5A, 16'hA5A5, 6'd0,  1'b0}, 1'b0, NO_ENTRY}
  };

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [fhl_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic [fhl_pkg::KIND_W-1:0]      in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [fhl_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [0:0]                      cfg_index;
  logic [31:0]                     cfg_data;

  // Mirror of the log, kept by the predictor.
  logic [fhl_pkg::ID_W-1:0]   dev_store [LOG_DEPTH];
  logic [fhl_pkg::ID_W-1:0]   code_store [LOG_DEPTH];
  logic [fhl_pkg::TIME_W-1:0] stamp_store [LOG_DEPTH];
  logic                       ack_bits [LOG_DEPTH];
  logic                       ongoing_bits [LOG_DEPTH];
  int                         wr_slot;
  logic [fhl_pkg::TIME_W-1:0] tick_total;
  logic [fhl_pkg::TIME_W-1:0] base_time_q;
  logic [fhl_pkg::SLOT_W-1:0] scan_start_q;

  // Result words predicted for accepted commands, oldest first.
  log_word_t awaited_words [$];

  // Last raised pair, so random raises can repeat it and hit the refresh path.
  logic [fhl_pkg::ID_W-1:0] last_device;
  logic [fhl_pkg::ID_W-1:0] last_code;

  int mismatch_count;
  int cycle_count;
  int send_idle_pct;
  int take_idle_pct;

  fault_history_log_core #(
    .LOG_DEPTH(LOG_DEPTH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The run is cut off at a generous bound; a hung handshake ends up here.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // The receiver stalls at random; new tready values land on the falling edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= take_idle_pct);
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("mismatch in %s: got %0h, want %0h", what, got, want);
    mismatch_count = mismatch_count + 1;
  endtask

  // Contents of one slot in the form of a result word; the count fields are
  // filled in by the caller.
  function automatic log_word_t entry_view(input int s);
    log_word_t r;
    r = '0;
    r.found   = 1'b1;
    r.slot    = fhl_pkg::SLOT_W'(s);
    r.device  = dev_store[s];
    r.code    = code_store[s];
    r.stamp   = stamp_store[s];
    r.acked   = ack_bits[s];
    r.ongoing = ongoing_bits[s];
    return r;
  endfunction

  // Applies one accepted command to the mirrored log and returns the word
  // the block must answer with.
  function automatic log_word_t apply_command(input command_t c);
    log_word_t                  r;
    logic [fhl_pkg::TIME_W-1:0] now;
    int                         prev;
    int                         j;
    int                         n_unacked;
    r   = '0;
    now = base_time_q + tick_total;
    case (c.kind)
      fhl_pkg::KIND_RAISE: begin
        prev = (wr_slot == 0) ? LOG_DEPTH - 1 : wr_slot - 1;
        if (dev_store[prev] == c.device && code_store[prev] == c.code) begin
          // Same fault as the newest entry: only its time moves.
          stamp_store[prev] = now;
          r = entry_view(prev);
        end else begin
          dev_store[wr_slot]    = c.device;
          code_store[wr_slot]   = c.code;
          stamp_store[wr_slot]  = now;
          ack_bits[wr_slot]     = 1'b0;
          ongoing_bits[wr_slot] = 1'b0;
          r = entry_view(wr_slot);
          wr_slot = (wr_slot + 1) % LOG_DEPTH;
        end
      end
      fhl_pkg::KIND_ACK: begin
        if (int'(c.slot) < LOG_DEPTH) begin
          ack_bits[c.slot] = 1'b1;
          r = entry_view(int'(c.slot));
        end
      end
      fhl_pkg::KIND_ONGOING: begin
        if (int'(c.slot) < LOG_DEPTH) begin
          ongoing_bits[c.slot] = c.flag;
          r = entry_view(int'(c.slot));
        end
      end
      fhl_pkg::KIND_READ: begin
        if (int'(c.slot) < LOG_DEPTH) r = entry_view(int'(c.slot));
      end
      fhl_pkg::KIND_NEXT: begin
        // Rotating search from scan_start, which wraps modulo the depth.
        for (int i = 0; i < LOG_DEPTH; i++) begin
          j = (int'(scan_start_q) + i) % LOG_DEPTH;
          if (!r.found && !ack_bits[j]) r = entry_view(j);
        end
      end
      fhl_pkg::KIND_TICK: tick_total = tick_total + 1;
      default: ;
    endcase
    n_unacked = 0;
    for (int i = 0; i < LOG_DEPTH; i++) begin
      if (!ack_bits[i]) n_unacked++;
    end
    r.unacked = fhl_pkg::COUNT_W'(n_unacked);
    r.wslot   = fhl_pkg::SLOT_W'(wr_slot);
    return r;
  endfunction

  // Random commands lean on raises so the ring fills, wraps and keeps
  // unacknowledged entries around for the search; acknowledges and reads
  // mostly hit real slots, with some indexes past the end.
  function automatic command_t random_command();
    command_t c;
    int       roll;
    c.device = fhl_pkg::ID_W'($urandom);
    c.code   = fhl_pkg::ID_W'($urandom);
    c.slot   = ($urandom_range(0, 99) < 85)
               ? fhl_pkg::SLOT_W'($urandom_range(0, LOG_DEPTH - 1))
               : fhl_pkg::SLOT_W'($urandom_range(0, 63));
    c.flag   = 1'($urandom);
    roll     = $urandom_range(0, 99);
    if (roll < 36)      c.kind = fhl_pkg::KIND_RAISE;
    else if (roll < 56) c.kind = fhl_pkg::KIND_ACK;
    else if (roll < 66) c.kind = fhl_pkg::KIND_ONGOING;
    else if (roll < 78) c.kind = fhl_pkg::KIND_READ;
    else if (roll < 90) c.kind = fhl_pkg::KIND_NEXT;
    else if (roll < 98) c.kind = fhl_pkg::KIND_TICK;
    else                c.kind = (roll[0]) ? KIND_SPARE_B : KIND_SPARE_A;
    if (c.kind == fhl_pkg::KIND_RAISE) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          c.device = last_device;
          c.code   = last_code;
        end
        4, 5, 6: begin
          c.device = fhl_pkg::ID_W'($urandom_range(16'hFFFC, 16'hFFFF));
          c.code   = fhl_pkg::ID_W'($urandom_range(0, 3));
        end
        default: ;
      endcase
      last_device = c.device;
      last_code   = c.code;
    end
    return c;
  endfunction

  // Offers one command word, holding it until accepted; starts and ends on
  // a falling edge.
  task automatic send_command(input command_t c, input logic typed,
                              input log_word_t want);
    log_word_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c.kind;
    in_tdata  <= {1'b0, c.flag, c.slot, c.code, c.device};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = apply_command(c);
    awaited_words.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Holds the sender off until every predicted word has come back, then
  // lets the block settle before anything else happens.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (awaited_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [0:0] index, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (index == fhl_pkg::REG_BASE_TIME) base_time_q = value;
    else                                 scan_start_q = value[fhl_pkg::SLOT_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Every accepted result word is checked field by field against the oldest
  // prediction.
  always @(posedge clk) begin : result_check
    log_word_t got;
    log_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.found   = out_tdata[0];
      got.slot    = out_tdata[6:1];
      got.device  = out_tdata[22:7];
      got.code    = out_tdata[38:23];
      got.stamp   = out_tdata[70:39];
      got.acked   = out_tdata[71];
      got.ongoing = out_tdata[72];
      got.unacked = out_tdata[79:73];
      got.wslot   = out_tdata[85:80];
      if (awaited_words.size() == 0) begin
        report_mismatch("result word with none awaited", 64'd1, 64'd0);
      end else begin
        want = awaited_words.pop_front();
        if (got.found !== want.found)
          report_mismatch("found", 64'(got.found), 64'(want.found));
        if (got.slot !== want.slot)
          report_mismatch("entry_slot", 64'(got.slot), 64'(want.slot));
        if (got.device !== want.device)
          report_mismatch("entry_device", 64'(got.device), 64'(want.device));
        if (got.code !== want.code)
          report_mismatch("entry_code", 64'(got.code), 64'(want.code));
        if (got.stamp !== want.stamp)
          report_mismatch("entry_time", 64'(got.stamp), 64'(want.stamp));
        if (got.acked !== want.acked)
          report_mismatch("entry_acked", 64'(got.acked), 64'(want.acked));
        if (got.ongoing !== want.ongoing)
          report_mismatch("entry_ongoing", 64'(got.ongoing), 64'(want.ongoing));
        if (got.unacked !== want.unacked)
          report_mismatch("unacked_count", 64'(got.unacked), 64'(want.unacked));
        if (got.wslot !== want.wslot)
          report_mismatch("write_slot", 64'(got.wslot), 64'(want.wslot));
      end
    end
  end

  initial begin : stimulus
    logic [31:0]                base_plan;
    logic [fhl_pkg::SLOT_W-1:0] scan_plan;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    out_tready     = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = fhl_pkg::REG_BASE_TIME;
    cfg_data       = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    send_idle_pct  = 6;
    take_idle_pct  = 61;
    last_device    = '0;
    last_code      = '0;
    // The mirror starts in the filler state the block resets to.
    for (int i = 0; i < LOG_DEPTH; i++) begin
      dev_store[i]    = fhl_pkg::FILLER_ID;
      code_store[i]   = fhl_pkg::FILLER_ID;
      stamp_store[i]  = '0;
      ack_bits[i]     = 1'b1;
      ongoing_bits[i] = 1'b0;
    end
    wr_slot      = 0;
    tick_total   = '0;
    base_time_q  = '0;
    scan_start_q = '0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int r = 0; r < N_DIRECTED; r++) begin
      send_command(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
    end
    wait_idle();

    // Random phases. Idling goes sender-light/receiver-heavy, then the
    // reverse, then none at all; the registers change at every phase
    // boundary, covering both ends of each and a base time that wraps.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase / 2)
        0: begin
          send_idle_pct = 6;
          take_idle_pct = 61;
        end
        1: begin
          send_idle_pct = 61;
          take_idle_pct = 6;
        end
        default: begin
          send_idle_pct = 0;
          take_idle_pct = 0;
        end
      endcase
      case (phase)
        0: begin
          base_plan = 32'h0000_0000;
          scan_plan = 6'd0;
        end
        1: begin
          base_plan = 32'hFFFF_FFF0;
          scan_plan = 6'd63;
        end
        2: begin
          base_plan = 32'hFFFF_FFFF;
          scan_plan = 6'd31;
        end
        4: begin
          base_plan = 32'h8000_0000;
          scan_plan = 6'd32;
        end
        default: begin
          base_plan = $urandom;
          scan_plan = fhl_pkg::SLOT_W'($urandom_range(0, 63));
        end
      endcase
      write_register(fhl_pkg::REG_BASE_TIME, base_plan);
      write_register(fhl_pkg::REG_SCAN_START, {26'd0, scan_plan});
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // Midway, the sender stops until the block has answered everything.
        if (n == PHASE_WORDS / 2) wait_idle();
        send_command(random_command(), 1'b0, NO_ENTRY);
      end
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

[sim.f]
sv/fhl_pkg.sv
sv/fhl_ram.sv
sv/fhl_scan.sv
sv/fault_history_log_core.sv
tb/sv/tb_top.sv
